[hw/rtl/wpsm_pkg.sv]
// ----------------------------------------------------------------------------
// wpsm_pkg
// Shared types and constants of the windowed pulse speed meter.
// ----------------------------------------------------------------------------
`default_nettype none

package wpsm_pkg;

  localparam int unsigned MS_W     = 32;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned MPP_W    = 24;
  localparam int unsigned SPEED_W  = 32;
  localparam int unsigned NUM_W    = CNT_W + MPP_W;
  localparam int unsigned SCL_W    = NUM_W + 12;
  localparam int unsigned DIV_STEPS = SPEED_W;
  localparam int unsigned DSW      = $clog2(DIV_STEPS);

  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QAW      = $clog2(QDEPTH);
  localparam int unsigned QCW      = QAW + 1;

  localparam int unsigned CFG_AW   = 2;
  localparam int unsigned CFG_DW   = 32;

  localparam logic [MS_W-1:0] WINDOW_RESET  = 32'd1000;
  localparam logic [MS_W-1:0] TIMEOUT_RESET = 32'd2000;

  localparam logic REQ_PULSE  = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  typedef enum logic [CFG_AW-1:0] {
    CFG_ENABLE  = 2'd0,
    CFG_MPP     = 2'd1,
    CFG_WINDOW  = 2'd2,
    CFG_TIMEOUT = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic            req_type;
    logic [MS_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic               configured;
    logic               valid_res;
    logic               stale;
    logic [SPEED_W-1:0] speed_kmh;
    logic [CNT_W-1:0]   total_pulses;
    logic [MS_W-1:0]    last_pulse_time;
  } out_item_t;

  typedef struct packed {
    logic [MS_W-1:0]  now_ms;
    logic [CNT_W-1:0] pulse_count;
    logic [MS_W-1:0]  pulse_time;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

[hw/rtl/windowed_pulse_speed_meter_top.sv]
// ----------------------------------------------------------------------------
// windowed_pulse_speed_meter_top
// Pulse counting speed meter with a sampling window, stale detection and
// saturating Q16.16 km/h output.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  input    push / full          in_data  (req_type, now_ms)
//  result   empty / pop          out_data (status, speed, count, pulse time)
//  config   cfg_we               cfg_addr, cfg_wdata
//
//  Pulse items are taken one per cycle while full is low and yield no result.
//  An update passes S_IDLE and S_FIN in the back part; when the window closes
//  also S_MUL, S_SCALE, S_CHECK and, unless saturated, the 32-step divider.
//  Up to four updates wait in the command queue; full rises when it is full.
//  Reset is synchronous; nothing is lost while pop is held low.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_pulse_speed_meter_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  output logic                             full,
  input  wire wpsm_pkg::in_item_t          in_data,
  output logic                             empty,
  input  wire logic                        pop,
  output wpsm_pkg::out_item_t              out_data,
  input  wire logic                        cfg_we,
  input  wire logic [wpsm_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [wpsm_pkg::CFG_DW-1:0] cfg_wdata
);
  import wpsm_pkg::*;

  logic    q_push;
  logic    q_pop;
  cmd_t    q_cmd;
  cmd_t    q_head;
  q_stat_t q_stat;

  wpsm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_data (in_data),
    .q_stat  (q_stat),
    .full    (full),
    .q_push  (q_push),
    .q_cmd   (q_cmd)
  );

  wpsm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .q_head  (q_head),
    .q_stat  (q_stat)
  );

  wpsm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .q_head    (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[hw/rtl/wpsm_front.sv]
// ----------------------------------------------------------------------------
// wpsm_front
// Input stage: counts pulses and hands update ticks with a snapshot of the
// pulse state to the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wpsm_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire wpsm_pkg::in_item_t in_data,
  input  wire wpsm_pkg::q_stat_t q_stat,
  output logic                   full,
  output logic                   q_push,
  output wpsm_pkg::cmd_t         q_cmd
);
  import wpsm_pkg::*;

  logic [CNT_W-1:0] pulse_count_r;
  logic [MS_W-1:0]  pulse_time_r;
  logic             accept;

  assign full   = q_stat.full;
  assign accept = push && !q_stat.full;
  assign q_push = accept && (in_data.req_type == REQ_UPDATE);

  assign q_cmd.now_ms      = in_data.now_ms;
  assign q_cmd.pulse_count = pulse_count_r;
  assign q_cmd.pulse_time  = pulse_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_count_r <= '0;
      pulse_time_r  <= '0;
    end else if (accept && (in_data.req_type == REQ_PULSE)) begin
      pulse_count_r <= pulse_count_r + CNT_W'(1);
      pulse_time_r  <= in_data.now_ms;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/wpsm_queue.sv]
// ----------------------------------------------------------------------------
// wpsm_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module wpsm_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_push,
  input  wire wpsm_pkg::cmd_t q_cmd,
  input  wire logic           q_pop,
  output wpsm_pkg::cmd_t      q_head,
  output wpsm_pkg::q_stat_t   q_stat
);
  import wpsm_pkg::*;

  cmd_t           entry_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QCW-1:0] fill_r;
  logic           do_push;
  logic           do_pop;

  assign q_stat.full  = (fill_r == QCW'(QDEPTH));
  assign q_stat.empty = (fill_r == '0);
  assign do_push      = q_push && !q_stat.full;
  assign do_pop       = q_pop && !q_stat.empty;
  assign q_head       = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + QCW'(1);
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - QCW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/wpsm_back.sv]
// ----------------------------------------------------------------------------
// wpsm_back
// Execution stage: window bookkeeping, speed computation with a bit-serial
// divider, status flags and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wpsm_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [wpsm_pkg::CFG_AW-1:0]     cfg_addr,
  input  wire logic [wpsm_pkg::CFG_DW-1:0]     cfg_wdata,
  input  wire wpsm_pkg::cmd_t                  q_head,
  input  wire wpsm_pkg::q_stat_t               q_stat,
  output logic                                 q_pop,
  input  wire logic                            pop,
  output logic                                 empty,
  output wpsm_pkg::out_item_t                  out_data
);
  import wpsm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SCALE,
    S_CHECK,
    S_DIV,
    S_FIN
  } state_t;

  state_t             state_r;

  logic               enable_r;
  logic [MPP_W-1:0]   mpp_r;
  logic [MS_W-1:0]    window_r;
  logic [MS_W-1:0]    timeout_r;

  logic [MS_W-1:0]    wst_r;
  logic [CNT_W-1:0]   wsc_r;
  logic [SPEED_W-1:0] held_speed_r;

  logic               cfg_ok_r;
  logic               valid_r;
  logic               stale_r;
  logic               did_div_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [MS_W-1:0]    ptime_r;
  logic [CNT_W-1:0]   delta_r;
  logic [MS_W-1:0]    elap_r;
  logic [NUM_W-1:0]   num_r;
  logic [SCL_W-1:0]   scaled_r;
  logic [MS_W-1:0]    rem_r;
  logic [SPEED_W-1:0] quo_r;
  logic [DSW-1:0]     step_r;

  logic               out_valid_r;
  out_item_t          out_r;

  logic               cfg_ok;
  logic [MS_W-1:0]    elapsed;
  logic               win_hit;
  logic [MS_W-1:0]    age;
  logic               is_stale;
  logic               no_pulse;
  logic               need_div;
  logic [MS_W:0]      shl;
  logic               ge;
  logic [MS_W:0]      diff;
  logic [SPEED_W-1:0] held_nxt;
  logic               out_load;

  assign cfg_ok   = enable_r && (mpp_r != '0);
  assign elapsed  = q_head.now_ms - wst_r;
  assign win_hit  = (elapsed >= window_r);
  assign age      = q_head.now_ms - q_head.pulse_time;
  assign is_stale = (q_head.pulse_time != '0) && (age > timeout_r);
  assign no_pulse = (q_head.pulse_count == '0);
  assign need_div = cfg_ok && win_hit && (elapsed != '0);

  assign q_pop    = (state_r == S_IDLE) && !q_stat.empty;

  assign shl  = {rem_r, quo_r[SPEED_W-1]};
  assign ge   = (shl >= {1'b0, elap_r});
  assign diff = shl - {1'b0, elap_r};

  assign held_nxt = valid_r ? (did_div_r ? quo_r : held_speed_r) : '0;
  assign out_load = (state_r == S_FIN) && (!out_valid_r || pop);

  assign empty    = !out_valid_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      mpp_r     <= '0;
      window_r  <= WINDOW_RESET;
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_ENABLE:  enable_r  <= cfg_wdata[0];
        CFG_MPP:     mpp_r     <= cfg_wdata[MPP_W-1:0];
        CFG_WINDOW:  window_r  <= cfg_wdata[MS_W-1:0];
        CFG_TIMEOUT: timeout_r <= cfg_wdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wst_r        <= '0;
      wsc_r        <= '0;
      held_speed_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (pop && out_valid_r && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!q_stat.empty) begin
            cfg_ok_r  <= cfg_ok;
            valid_r   <= cfg_ok && !no_pulse && !is_stale;
            stale_r   <= cfg_ok && !no_pulse && is_stale;
            did_div_r <= need_div;
            cnt_r     <= q_head.pulse_count;
            ptime_r   <= q_head.pulse_time;
            delta_r   <= q_head.pulse_count - wsc_r;
            elap_r    <= elapsed;
            if (cfg_ok && win_hit) begin
              wst_r <= q_head.now_ms;
              wsc_r <= q_head.pulse_count;
            end
            state_r <= need_div ? S_MUL : S_FIN;
          end
        end
        S_MUL: begin
          num_r   <= NUM_W'(delta_r) * NUM_W'(mpp_r);
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          // times 3600 = 4096 - 512 + 16
          scaled_r <= (SCL_W'(num_r) << 12) - (SCL_W'(num_r) << 9) + (SCL_W'(num_r) << 4);
          state_r  <= S_CHECK;
        end
        S_CHECK: begin
          if (scaled_r[SCL_W-1:SPEED_W] >= (SCL_W-SPEED_W)'(elap_r)) begin
            quo_r   <= '1;
            state_r <= S_FIN;
          end else begin
            rem_r   <= scaled_r[SPEED_W+MS_W-1:SPEED_W];
            quo_r   <= scaled_r[SPEED_W-1:0];
            step_r  <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r  <= ge ? diff[MS_W-1:0] : shl[MS_W-1:0];
          quo_r  <= {quo_r[SPEED_W-2:0], ge};
          step_r <= step_r + DSW'(1);
          if (step_r == DSW'(DIV_STEPS - 1)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_load) begin
            held_speed_r          <= held_nxt;
            out_valid_r           <= 1'b1;
            out_r.configured      <= cfg_ok_r;
            out_r.valid_res       <= valid_r;
            out_r.stale           <= stale_r;
            out_r.speed_kmh       <= held_nxt;
            out_r.total_pulses    <= cnt_r;
            out_r.last_pulse_time <= ptime_r;
            state_r               <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/wpsm_checker.sv]
// ----------------------------------------------------------------------------
// wpsm_checker
// Port-level checks of the speed meter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wpsm_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                empty,
  input wire logic                pop,
  input wire wpsm_pkg::out_item_t out_data
);
  import wpsm_pkg::*;

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result waiting right after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting result changed or vanished");

  a_unconfigured_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_data.configured) |->
      (out_data.speed_kmh == '0 && !out_data.valid_res && !out_data.stale))
    else $error("unconfigured result carries speed or status");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_data.valid_res) |-> (out_data.speed_kmh == '0))
    else $error("invalid result carries nonzero speed");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> !(out_data.valid_res && out_data.stale))
    else $error("result both valid and stale");

endmodule

bind windowed_pulse_speed_meter_top wpsm_checker u_wpsm_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);

`default_nettype wire
